FILE: hdl/gbfe_pkg.sv
// Shared types and constants for the GNSS binary frame extractor.
// No dependencies; every other file but gbfe_cell imports this package.
package gbfe_pkg;

   // Default depth of the frame buffer; sets the width of the write position.
   localparam int BUF_DEPTH_DEF = 64;

   // Byte that closes a frame.
   localparam logic [7:0] END_BYTE = 8'h55;

   // Length of the longest frame kind; the byte chain holds this many cells.
   localparam int MAX_LEN = 41;
   localparam int TAP_W   = MAX_LEN * 8;

   // Exact stored lengths of the frame kinds.
   localparam int LEN_TIME    = 18;
   localparam int LEN_LATLON  = 41;
   localparam int LEN_VEL     = 27;
   localparam int LEN_NED     = 29;
   localparam int LEN_ECEF    = 27;
   localparam int LEN_HEADING = 17;

   // First and second identifying bytes of the frame kinds.
   localparam logic [7:0] ID0_TIME    = 8'h00;
   localparam logic [7:0] ID0_LATLON  = 8'h01;
   localparam logic [7:0] ID0_VEL     = 8'h04;
   localparam logic [7:0] ID0_NED     = 8'h03;
   localparam logic [7:0] ID0_ECEF    = 8'h02;
   localparam logic [7:0] ID0_HEADING = 8'h07;
   localparam logic [7:0] ID1_TIME    = 8'h01;
   localparam logic [7:0] ID1_NAV     = 8'h02;

   localparam logic [19:0] SECS_PER_WEEK = 20'd604800;

   // One fresh mark per matched kind; the low five form a complete set.
   localparam int MARK_W = 6;
   localparam logic [MARK_W-1:0] SET_MASK = 6'b01_1111;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_TIME    = 3'd1,
      KIND_LATLON  = 3'd2,
      KIND_VEL     = 3'd3,
      KIND_NED     = 3'd4,
      KIND_ECEF    = 3'd5,
      KIND_HEADING = 3'd6
   } kind_type;

   typedef struct packed {
      logic        set_complete;
      logic [7:0]  status_byte;
      logic [7:0]  sat_count;
      logic [63:0] word_c;
      logic [63:0] word_b;
      logic [63:0] word_a;
      kind_type    frame_kind;
   } result_type;

endpackage

FILE: hdl/gbfe_cell.sv
// One byte cell of the frame capture chain.
// Depends on nothing; instanced in a row by the top level.
module gbfe_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   // Take the neighbor's byte on a shift, otherwise hold.
   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   assign byte_out = byte_ff;

endmodule

FILE: hdl/gbfe_decode.sv
// Frame kind match and field extraction over the taps of the byte chain.
// Depends on gbfe_pkg.
module gbfe_decode import gbfe_pkg::*; #(
   parameter int POS_W = 6
) (
   input  logic [TAP_W-1:0]  taps,
   input  logic [POS_W-1:0]  position,
   input  logic [MARK_W-1:0] marks,
   output result_type        result,
   output logic [MARK_W-1:0] marks_next
);

   localparam int TAP_IDX_W = $clog2(TAP_W);

   // The newest byte sits in tap 0, so byte i of an n-byte frame is tap n-1-i.
   function automatic logic [7:0] frame_byte(input logic [TAP_W-1:0] t,
                                              input int n, input int i);
      return t[TAP_IDX_W'((n - 1 - i) * 8) +: 8];
   endfunction

   function automatic logic [63:0] le_word(input logic [TAP_W-1:0] t, input int n,
                                           input int first, input int count);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < count) begin
            v[6'(k * 8) +: 8] = t[TAP_IDX_W'((n - 1 - first - k) * 8) +: 8];
         end
      end
      return v;
   endfunction

   function automatic logic frame_matches(input logic [TAP_W-1:0] t,
                                          input logic [POS_W-1:0] p,
                                          input int n, input logic [7:0] id0,
                                          input logic [7:0] id1);
      return (p == POS_W'(n)) && (frame_byte(t, n, 0) == id0) &&
             (frame_byte(t, n, 1) == id1);
   endfunction

   kind_type          kind;
   logic [35:0]       week_secs;
   logic [MARK_W-1:0] marks_set;

   always_comb begin
      if (frame_matches(taps, position, LEN_TIME, ID0_TIME, ID1_TIME)) begin
         kind = KIND_TIME;
      end else if (frame_matches(taps, position, LEN_LATLON, ID0_LATLON, ID1_NAV)) begin
         kind = KIND_LATLON;
      end else if (frame_matches(taps, position, LEN_VEL, ID0_VEL, ID1_NAV)) begin
         kind = KIND_VEL;
      end else if (frame_matches(taps, position, LEN_NED, ID0_NED, ID1_NAV)) begin
         kind = KIND_NED;
      end else if (frame_matches(taps, position, LEN_ECEF, ID0_ECEF, ID1_NAV)) begin
         kind = KIND_ECEF;
      end else if (frame_matches(taps, position, LEN_HEADING, ID0_HEADING, ID1_NAV)) begin
         kind = KIND_HEADING;
      end else begin
         kind = KIND_NONE;
      end
   end

   // Week number times seconds per week, for the absolute timestamp.
   assign week_secs = 36'(le_word(taps, LEN_TIME, 5, 2)) * 36'(SECS_PER_WEEK);

   always_comb begin
      result              = '0;
      result.frame_kind   = kind;
      unique case (kind)
         KIND_TIME: begin
            result.word_a = le_word(taps, LEN_TIME, 5, 2);
            result.word_b = le_word(taps, LEN_TIME, 7, 4);
            result.word_c = 64'(week_secs) + le_word(taps, LEN_TIME, 7, 4);
         end
         KIND_LATLON: begin
            result.word_a      = le_word(taps, LEN_LATLON, 9, 8);
            result.word_b      = le_word(taps, LEN_LATLON, 17, 8);
            result.word_c      = le_word(taps, LEN_LATLON, 25, 8);
            result.status_byte = frame_byte(taps, LEN_LATLON, 38);
         end
         KIND_VEL: begin
            result.word_a    = le_word(taps, LEN_VEL, 9, 4);
            result.word_b    = le_word(taps, LEN_VEL, 13, 4);
            result.word_c    = le_word(taps, LEN_VEL, 17, 4);
            result.sat_count = frame_byte(taps, LEN_VEL, 23);
         end
         KIND_NED: begin
            result.word_a      = le_word(taps, LEN_NED, 9, 4);
            result.word_b      = le_word(taps, LEN_NED, 13, 4);
            result.word_c      = le_word(taps, LEN_NED, 17, 4);
            result.sat_count   = frame_byte(taps, LEN_NED, 25);
            result.status_byte = frame_byte(taps, LEN_NED, 26);
         end
         KIND_ECEF: begin
            result.word_a      = le_word(taps, LEN_ECEF, 9, 4);
            result.word_b      = le_word(taps, LEN_ECEF, 13, 4);
            result.word_c      = le_word(taps, LEN_ECEF, 17, 4);
            result.sat_count   = frame_byte(taps, LEN_ECEF, 23);
            result.status_byte = frame_byte(taps, LEN_ECEF, 24);
         end
         KIND_HEADING: begin
            result.word_a      = le_word(taps, LEN_HEADING, 9, 4);
            result.status_byte = frame_byte(taps, LEN_HEADING, 11);
         end
         default: begin
         end
      endcase

      // An unmatched frame leaves the marks alone.
      if (kind == KIND_NONE) begin
         marks_set = marks;
      end else begin
         marks_set = marks | (MARK_W'(1) << (3'(kind) - 3'd1));
      end

      if ((marks_set & SET_MASK) == SET_MASK) begin
         result.set_complete = 1'b1;
         marks_next          = '0;
      end else begin
         marks_next          = marks_set;
      end
   end

endmodule

FILE: hdl/gbfe_outq.sv
// Two-entry result queue: an output register with a skid register behind it.
// Depends on gbfe_pkg.
module gbfe_outq import gbfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            // Push cannot happen here: the queue reports full.
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

FILE: hdl/gnss_binary_frame_extractor_top.sv
// Top level of the GNSS binary frame extractor.
// Depends on gbfe_pkg, gbfe_cell, gbfe_decode and gbfe_outq.
//
// Usage: receiver bytes enter one word at a time on the req_ stream. Every
// byte other than 0x55 is appended to the current frame; 0x55 closes it. A
// closed frame produces exactly one word on the rsp_ stream, through the
// registered result queue. That word carries the frame kind in tuser
// (zero when nothing matched), the little-endian fields in tdata and, in
// tlast, a flag that the time, position, velocity, NED and ECEF kinds have
// all been seen since the last complete set.
// Throughput is one byte per cycle while req_tready is high. Bytes shift
// through a row of byte cells, one cell per byte of the longest frame kind,
// so the fields of a closed frame sit at fixed taps and are decoded in the
// cycle the closing byte arrives. Bytes past BUF_DEPTH-1 in one frame are
// dropped; such a frame matches nothing. Reset (synchronous, active high)
// clears the write position, the fresh marks and the result queue; the
// byte cells need no reset. When the receiver stalls, up to two results are
// held; req_tready falls only while both are waiting, so bytes keep flowing
// while one result is pending.
module gnss_binary_frame_extractor_top import gbfe_pkg::*; #(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // in_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // word_a [63:0], word_b [127:64], word_c [191:128],
   // sat_count [199:192], status_byte [207:200]
   output logic [207:0]  rsp_tdata,
   output logic [2:0]    rsp_tuser,   // frame_kind
   output logic          rsp_tlast    // set_complete
);

   localparam int POS_W = $clog2(BUF_DEPTH);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(BUF_DEPTH - 1);

   logic [POS_W-1:0]  position_ff, position_in;
   logic [MARK_W-1:0] marks_ff, marks_in;
   logic [MARK_W-1:0] marks_next;
   logic              accept;
   logic              is_end;
   logic              shift_en;
   logic              queue_full;
   logic [7:0]        chain [MAX_LEN+1];
   logic [TAP_W-1:0]  taps;
   result_type        frame_result;
   result_type        rsp_data;

   assign accept   = req_tvalid & req_tready;
   assign is_end   = (req_tdata == END_BYTE);
   assign shift_en = accept & ~is_end & (position_ff != POS_MAX);

   // Byte chain: cell 0 holds the newest byte of the frame.
   assign chain[0] = req_tdata;
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      gbfe_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (chain[i]),
         .byte_out (chain[i+1])
      );
      assign taps[i * 8 +: 8] = chain[i+1];
   end

   gbfe_decode #(
      .POS_W (POS_W)
   ) u_decode (
      .taps       (taps),
      .position   (position_ff),
      .marks      (marks_ff),
      .result     (frame_result),
      .marks_next (marks_next)
   );

   always_comb begin
      position_in = position_ff;
      marks_in    = marks_ff;
      if (accept && is_end) begin
         position_in = '0;
         marks_in    = marks_next;
      end else if (shift_en) begin
         position_in = position_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         marks_ff    <= '0;
      end else begin
         position_ff <= position_in;
         marks_ff    <= marks_in;
      end
   end

   gbfe_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & is_end),
      .push_data (frame_result),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign req_tready = ~queue_full;
   assign rsp_tdata  = {rsp_data.status_byte, rsp_data.sat_count,
                        rsp_data.word_c, rsp_data.word_b, rsp_data.word_a};
   assign rsp_tuser  = rsp_data.frame_kind;
   assign rsp_tlast  = rsp_data.set_complete;

endmodule

FILE: test/gbfe_frame_checker.sv
// Scoreboard for the GNSS binary frame extractor: it tracks every byte word the block
// accepts, predicts each result word, and compares the block's output field by field.
// Depends on gbfe_pkg for the frame kinds, lengths, identifying bytes and result layout.
module gbfe_frame_checker import gbfe_pkg::*; #(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [207:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           mismatch_count,
   output int           frames_pending,
   output int           frames_checked,
   output int           sets_seen
);

   localparam int IDX_W = $clog2(BUF_DEPTH);

   logic [7:0]        frame_buf [BUF_DEPTH];
   int                fill_level = 0;
   logic [MARK_W-1:0] fresh_marks = '0;
   result_type        pending_frames [$];
   int                errors = 0;
   int                checked = 0;
   int                sets = 0;

   function automatic logic [63:0] le_bytes(input int first, input int count);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < count; k++) begin
         v[6'(8*k) +: 8] = frame_buf[IDX_W'(first + k)];
      end
      return v;
   endfunction

   // Classifies the stored frame, fills in its fields and updates the fresh marks.
   // The length is tested first, so only bytes of the current frame are read.
   function automatic result_type decode_closed_frame();
      result_type r;
      kind_type   k;
      r = '0;
      k = KIND_NONE;
      if (fill_level == LEN_TIME && frame_buf[0] == ID0_TIME && frame_buf[1] == ID1_TIME)
         k = KIND_TIME;
      else if (fill_level == LEN_LATLON && frame_buf[0] == ID0_LATLON &&
               frame_buf[1] == ID1_NAV)
         k = KIND_LATLON;
      else if (fill_level == LEN_VEL && frame_buf[0] == ID0_VEL && frame_buf[1] == ID1_NAV)
         k = KIND_VEL;
      else if (fill_level == LEN_NED && frame_buf[0] == ID0_NED && frame_buf[1] == ID1_NAV)
         k = KIND_NED;
      else if (fill_level == LEN_ECEF && frame_buf[0] == ID0_ECEF && frame_buf[1] == ID1_NAV)
         k = KIND_ECEF;
      else if (fill_level == LEN_HEADING && frame_buf[0] == ID0_HEADING &&
               frame_buf[1] == ID1_NAV)
         k = KIND_HEADING;

      r.frame_kind = k;
      case (k) inside
         KIND_TIME: begin
            r.word_a = le_bytes(5, 2);
            r.word_b = le_bytes(7, 4);
            r.word_c = r.word_b + r.word_a * SECS_PER_WEEK;
         end
         KIND_LATLON: begin
            r.word_a      = le_bytes(9, 8);
            r.word_b      = le_bytes(17, 8);
            r.word_c      = le_bytes(25, 8);
            r.status_byte = frame_buf[38];
         end
         KIND_VEL, KIND_NED, KIND_ECEF: begin
            r.word_a = le_bytes(9, 4);
            r.word_b = le_bytes(13, 4);
            r.word_c = le_bytes(17, 4);
            if (k == KIND_VEL) begin
               r.sat_count = frame_buf[23];
            end else if (k == KIND_NED) begin
               r.sat_count   = frame_buf[25];
               r.status_byte = frame_buf[26];
            end else begin
               r.sat_count   = frame_buf[23];
               r.status_byte = frame_buf[24];
            end
         end
         KIND_HEADING: begin
            // The status byte sits inside the heading word.
            r.word_a      = le_bytes(9, 4);
            r.status_byte = frame_buf[11];
         end
         default: begin
         end
      endcase

      if (k != KIND_NONE) begin
         fresh_marks[3'(k) - 3'd1] = 1'b1;
         if ((fresh_marks & SET_MASK) == SET_MASK) begin
            r.set_complete = 1'b1;
            fresh_marks    = '0;
         end
      end
      fill_level = 0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("MISMATCH result %0d field %s: expected %h, got %h",
                     checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fill_level  = 0;
         fresh_marks = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("MISMATCH unexpected result word: kind %0d data %h",
                           rsp_tuser, rsp_tdata);
            end else begin
               want = pending_frames.pop_front();
               check_field("frame_kind", 64'(want.frame_kind), 64'(rsp_tuser));
               check_field("word_a", want.word_a, rsp_tdata[63:0]);
               check_field("word_b", want.word_b, rsp_tdata[127:64]);
               check_field("word_c", want.word_c, rsp_tdata[191:128]);
               check_field("sat_count", 64'(want.sat_count), 64'(rsp_tdata[199:192]));
               check_field("status_byte", 64'(want.status_byte), 64'(rsp_tdata[207:200]));
               check_field("set_complete", 64'(want.set_complete), 64'(rsp_tlast));
               if (want.set_complete)
                  sets++;
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata == END_BYTE) begin
               pending_frames.push_back(decode_closed_frame());
            end else if (fill_level < BUF_DEPTH - 1) begin
               frame_buf[IDX_W'(fill_level)] = req_tdata;
               fill_level++;
            end
         end
      end
      mismatch_count <= errors;
      frames_pending <= pending_frames.size();
      frames_checked <= checked;
      sets_seen      <= sets;
   end

endmodule

FILE: test/tb_gnss_binary_frame_extractor_top.sv
// Testbench top for the GNSS binary frame extractor: clock, reset, byte stimulus,
// random stalls on the result side and the final verdict.
// Depends on gbfe_pkg, the block's RTL and the gbfe_frame_checker scoreboard.
module tb_gnss_binary_frame_extractor_top;
   import gbfe_pkg::*;

   // Payload content for a generated frame: random bytes, or all-zero or all-one
   // bytes to hit the extremes of every field.
   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_mode_type;

   // Cycle limit for the safety net, far beyond the length of a correct run.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PERCENT  = 17;
   localparam int LONG_STALL    = 24;
   // Total number of byte words for the whole run, directed part included.
   localparam int RANDOM_BYTES  = 800;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // in_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;           // word_a, word_b, word_c, sat_count, status_byte
   logic [2:0]   rsp_tuser;           // frame_kind
   logic         rsp_tlast;           // set_complete

   // While calm is high neither side idles; this gives one long stretch at full rate.
   logic         calm = 1'b0;
   int           stall_left = 0;
   int           cycle_count = 0;
   int           bytes_sent = 0;
   int           frames_sent = 0;

   int           mismatch_count;
   int           frames_pending;
   int           frames_checked;
   int           sets_seen;

   kind_type     all_kinds [6] = '{KIND_TIME, KIND_LATLON, KIND_VEL,
                                   KIND_NED, KIND_ECEF, KIND_HEADING};

   gnss_binary_frame_extractor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   gbfe_frame_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending),
      .frames_checked (frames_checked),
      .sets_seen      (sets_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, frames_pending);
         $display("tb_gnss_binary_frame_extractor_top NOT OK");
         $finish;
      end
   end

   // Result side. Outside the calm stretch the receiver drops tready at random,
   // about 17 percent of the time, and now and then holds it low for a long stall
   // so that two results pile up and the block has to push back on the byte stream.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 999) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= LONG_STALL;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Offers one byte word and returns at the clock edge that accepts it. Random
   // idle cycles come before the word, so gaps land at every position in a frame.
   // tready is read right after the edge, before any register of the block updates.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Payload bytes never take the end-of-frame value, which would close the frame.
   function automatic logic [7:0] payload_byte(input fill_mode_type mode);
      logic [7:0] b;
      case (mode)
         FILL_ZERO: b = 8'h00;
         FILL_ONES: b = 8'hFF;
         default: begin
            case ($urandom_range(0, 7))
               0: b = 8'h00;
               1: b = 8'hFF;
               default: begin
                  b = END_BYTE;
                  while (b == END_BYTE)
                     b = 8'($urandom_range(0, 255));
               end
            endcase
         end
      endcase
      return b;
   endfunction

   function automatic int frame_len(input kind_type k);
      case (k)
         KIND_TIME:    return LEN_TIME;
         KIND_LATLON:  return LEN_LATLON;
         KIND_VEL:     return LEN_VEL;
         KIND_NED:     return LEN_NED;
         KIND_ECEF:    return LEN_ECEF;
         KIND_HEADING: return LEN_HEADING;
         default:      return 0;
      endcase
   endfunction

   // Sends one frame and its closing byte. The stored length is the kind's nominal
   // length plus len_adjust (so KIND_NONE with an adjust gives a frame of random
   // bytes of that length); bad_id flips one bit of one identifying byte.
   task automatic send_frame(input kind_type k, input int len_adjust, input logic bad_id,
                             input fill_mode_type mode);
      logic [7:0] id0;
      logic [7:0] id1;
      int         len;
      case (k)
         KIND_TIME:    begin id0 = ID0_TIME;    id1 = ID1_TIME; end
         KIND_LATLON:  begin id0 = ID0_LATLON;  id1 = ID1_NAV;  end
         KIND_VEL:     begin id0 = ID0_VEL;     id1 = ID1_NAV;  end
         KIND_NED:     begin id0 = ID0_NED;     id1 = ID1_NAV;  end
         KIND_ECEF:    begin id0 = ID0_ECEF;    id1 = ID1_NAV;  end
         KIND_HEADING: begin id0 = ID0_HEADING; id1 = ID1_NAV;  end
         default: begin
            id0 = payload_byte(FILL_RANDOM);
            id1 = payload_byte(FILL_RANDOM);
         end
      endcase
      // A single flipped bit of these small identifiers never yields the end byte.
      if (bad_id) begin
         if ($urandom_range(0, 1))
            id0[3'($urandom_range(0, 7))] ^= 1'b1;
         else
            id1[3'($urandom_range(0, 7))] ^= 1'b1;
      end
      len = frame_len(k) + len_adjust;
      if (len < 0)
         len = 0;
      for (int i = 0; i < len; i++) begin
         if (i == 0)
            send_byte(id0);
         else if (i == 1)
            send_byte(id1);
         else
            send_byte(payload_byte(mode));
      end
      send_byte(END_BYTE);
      frames_sent++;
   endtask

   initial begin
      int sel;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty frame and a one-byte frame first.
      send_frame(KIND_NONE, 0, 1'b0, FILL_RANDOM);
      send_frame(KIND_NONE, 1, 1'b0, FILL_RANDOM);
      // Every kind with all-one payload: maximum week and time of week, and the set
      // completes on the ECEF frame. The heading frame after it starts a new mark.
      foreach (all_kinds[i])
         send_frame(all_kinds[i], 0, 1'b0, FILL_ONES);
      // Every kind again with all-zero payload, at full rate on both sides; the
      // heading mark left over from the previous pass must not make the set
      // complete any earlier.
      calm <= 1'b1;
      foreach (all_kinds[i])
         send_frame(all_kinds[i], 0, 1'b0, FILL_ZERO);
      calm <= 1'b0;
      // Lengths one off the nominal value, and a broken identifier.
      send_frame(KIND_TIME, 1, 1'b0, FILL_RANDOM);
      send_frame(KIND_HEADING, -1, 1'b0, FILL_RANDOM);
      send_frame(KIND_VEL, 0, 1'b1, FILL_RANDOM);
      // Frames at and past the point where the write position saturates.
      send_frame(KIND_LATLON, 22, 1'b0, FILL_RANDOM);
      send_frame(KIND_LATLON, 23, 1'b0, FILL_RANDOM);
      send_frame(KIND_TIME, 60, 1'b0, FILL_ONES);
      // A valid time frame right after the overlong one proves the position reset.
      send_frame(KIND_TIME, 0, 1'b0, FILL_RANDOM);

      // Hold off the byte stream until every result so far has been delivered.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0)
         @(posedge clock);

      // Random part: mostly well-formed frames with random content, the rest broken
      // frames, garbage and bursts of empty frames that stress the result queue.
      while (bytes_sent < RANDOM_BYTES) begin
         sel = $urandom_range(0, 99);
         if (sel < 72) begin
            send_frame(all_kinds[3'($urandom_range(0, 5))], 0, 1'b0, FILL_RANDOM);
         end else if (sel < 78) begin
            send_frame(all_kinds[3'($urandom_range(0, 5))],
                       $urandom_range(0, 1) ? $urandom_range(1, 2) : -$urandom_range(1, 2),
                       1'b0, FILL_RANDOM);
         end else if (sel < 84) begin
            send_frame(all_kinds[3'($urandom_range(0, 5))], 0, 1'b1, FILL_RANDOM);
         end else if (sel < 90) begin
            send_frame(KIND_NONE, $urandom_range(0, 80), 1'b0, FILL_RANDOM);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_frame(KIND_NONE, 0, 1'b0, FILL_RANDOM);
            end
         end
      end

      // Drain: wait for every expected result, then give the block time to show
      // any stray word before the verdict.
      req_tvalid <= 1'b0;
      calm       <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d frames of all six kinds, broken and overlong ones too;",
               bytes_sent, frames_sent);
      $display("checked %0d result words, %0d of them completing a set, with stalls on both sides.",
               frames_checked, sets_seen);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("tb_gnss_binary_frame_extractor_top OK");
      end else begin
         $display("tb_gnss_binary_frame_extractor_top NOT OK");
      end
      $finish;
   end

endmodule
